// ===== rtl/core/gcs_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and codes of the click synthesizer
package gcs_pkg;

	localparam int MAX_VOICES      = 16;
	localparam int SINE_TABLE_BITS = 10;

	localparam int VIDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int CNT_W  = $clog2(MAX_VOICES + 1);

	localparam int AMP_W    = 17;
	localparam int PH_W     = 16;
	localparam int X_W      = 16;
	localparam int MAG_W    = 15;
	localparam int T1_W     = 15;
	localparam int TERM_W   = 20;
	localparam int SUM_W    = TERM_W + VIDX_W + 2;
	localparam int X_SHIFT  = 17 - SINE_TABLE_BITS;

	localparam int MUL_A_W  = 32;
	localparam int MUL_B_W  = 17;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;

	localparam int SAMPLE_W    = 16;
	localparam int ACT_W       = 5;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_PAD_W   = OUT_TDATA_W - SAMPLE_W - 2 - ACT_W;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [AMP_W-1:0] AMP_ONE = 17'd65536;
	localparam logic [15:0]      COEF_A  = 16'd51472;
	localparam logic [15:0]      COEF_B  = 16'd21167;
	localparam logic [11:0]      COEF_C  = 12'd2611;
	localparam logic [X_W-1:0]   X_ONE   = 16'h8000;
	localparam logic [MAG_W-1:0] MAG_MAX = 15'h7fff;

	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-32768);

	typedef struct packed {
		logic [15:0] gain;
		logic [31:0] spawn_thr;
		logic [15:0] decay;
		logic [15:0] pitch;
		logic [16:0] cutoff;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		gain:      16'd4096,
		spawn_thr: 32'd4295,
		decay:     16'd64881,
		pitch:     16'd8344,
		cutoff:    17'd655
	};

	typedef enum logic [2:0] {
		REG_GAIN,
		REG_SPAWN_THR,
		REG_DECAY,
		REG_PITCH,
		REG_CUTOFF
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_X2,
		ST_MC,
		ST_MB,
		ST_MA,
		ST_MM,
		ST_MG,
		ST_MP,
		ST_MD,
		ST_WR,
		ST_SPAWN,
		ST_RETIRE,
		ST_FIN
	} state_t;

	// operand pairs of the shared multiplier
	typedef enum logic [2:0] {
		OP_XX,
		OP_C,
		OP_B,
		OP_A,
		OP_MAG,
		OP_GAIN,
		OP_PITCH,
		OP_DECAY
	} mul_op_t;

	typedef struct packed {
		logic [X_W-1:0]     x;
		logic [X_W-1:0]     x2;
		logic [T1_W-1:0]    t1;
		logic [15:0]        t2;
		logic [MAG_W-1:0]   mag;
		logic [AMP_W-1:0]   amp;
		logic [MUL_A_W-1:0] amp_mag;
		logic [15:0]        gain;
		logic [15:0]        pitch;
		logic [15:0]        decay;
	} mul_src_t;

endpackage

// ===== rtl/core/gcs_mul_unit.sv =====
`timescale 1ns / 1ps
// shared multiplier with operand select and registered product
module gcs_mul_unit (
	input  logic                          clk,
	input  gcs_pkg::mul_op_t              op,
	input  gcs_pkg::mul_src_t             src,
	output logic [gcs_pkg::PROD_W-1:0]    prod
);
	import gcs_pkg::*;

	logic [MUL_A_W-1:0] a;
	logic [MUL_B_W-1:0] b;
	logic [PROD_W-1:0]  prod_q;

	always_comb begin
		case (op)
			OP_XX: begin
				a = MUL_A_W'(src.x);
				b = MUL_B_W'(src.x);
			end
			OP_C: begin
				a = MUL_A_W'(src.x2);
				b = MUL_B_W'(COEF_C);
			end
			OP_B: begin
				a = MUL_A_W'(src.t1);
				b = MUL_B_W'(src.x2);
			end
			OP_A: begin
				a = MUL_A_W'(src.t2);
				b = MUL_B_W'(src.x);
			end
			OP_MAG: begin
				a = MUL_A_W'(src.mag);
				b = MUL_B_W'(src.amp);
			end
			OP_GAIN: begin
				a = src.amp_mag;
				b = MUL_B_W'(src.gain);
			end
			OP_PITCH: begin
				a = MUL_A_W'(src.pitch);
				b = MUL_B_W'(src.amp);
			end
			OP_DECAY: begin
				a = MUL_A_W'(src.decay);
				b = MUL_B_W'(src.amp);
			end
			default: begin
				a = '0;
				b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

// ===== rtl/core/geiger_click_synthesizer_core.sv =====
`timescale 1ns / 1ps
// top level of the geiger click synthesizer: sequencer, voice pool, ports
//
//  channel   dir  handshake               contents
//  s_*       in   s_tvalid / s_tready     random_draw
//  m_*       out  m_tvalid / m_tready     sample_out, clipped, spawn_dropped, active_voices
//  apb       in   psel & penable & pwrite gain, spawn_threshold, decay, pitch, cutoff
//
// each sample scans all MAX_VOICES slots; its length grows with the live voices,
// set by the single shared multiplier: nine steps per live voice
// s_tready is high only between samples; a finished sample waits in the output register
// and the next sample can be accepted while it waits
// reset empties the voice pool and loads the default register values
module geiger_click_synthesizer_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [gcs_pkg::IN_TDATA_W-1:0]     s_tdata,   // [31:0] random_draw
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [gcs_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [15:0] sample_out, [16] clipped,
	                                                      // [17] spawn_dropped,
	                                                      // [22:18] active_voices, [23] zero
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [gcs_pkg::PADDR_W-1:0]        paddr,
	input  logic [gcs_pkg::PDATA_W-1:0]        pwdata,
	output logic [gcs_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);
	import gcs_pkg::*;

	state_t state_q, state_nxt;
	cfg_t   cfg_q;

	logic [VIDX_W-1:0]     vidx_q;
	logic [MAX_VOICES-1:0] live_q;
	logic [AMP_W-1:0]      amp_mem_q [MAX_VOICES];
	logic [PH_W-1:0]       phase_mem_q [MAX_VOICES];

	logic [31:0]              draw_q;
	logic [AMP_W-1:0]         amp_q;
	logic [PH_W-1:0]          ph_q;
	logic [X_W-1:0]           x_q;
	logic [X_W-1:0]           x2_q;
	logic                     neg_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SAMPLE_W-1:0]      sample_q;
	logic                     clip_q;
	logic                     dropped_q;

	logic                     m_tvalid_q;
	logic [OUT_TDATA_W-1:0]   m_tdata_q;

	mul_op_t                  mul_op;
	mul_src_t                 mul_src;
	logic [PROD_W-1:0]        prod;

	logic                     accept;
	logic                     last_slot;
	logic                     out_load;
	logic                     cfg_wr;
	cfg_reg_t                 reg_sel;

	logic [SINE_TABLE_BITS-1:0]   sidx;
	logic [1:0]                   quad;
	logic [SINE_TABLE_BITS-3:0]   frac;
	logic [X_W-1:0]               x_raw;
	logic [X_W-1:0]               x_now;
	logic [X_W-1:0]               x2_now;
	logic [T1_W-1:0]              t1_now;
	logic [15:0]                  t2_now;
	logic [AMP_W-1:0]             p_now;
	logic [MAG_W-1:0]             mag_now;
	logic [TERM_W-1:0]            term;

	logic                     spawn_req;
	logic                     free_any;
	logic [VIDX_W-1:0]        free_idx;
	logic                     spawn_go;
	logic [CNT_W-1:0]         live_cnt;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_GAIN:      cfg_q.gain      <= pwdata[15:0];
				REG_SPAWN_THR: cfg_q.spawn_thr <= pwdata[31:0];
				REG_DECAY:     cfg_q.decay     <= pwdata[15:0];
				REG_PITCH:     cfg_q.pitch     <= pwdata[15:0];
				REG_CUTOFF:    cfg_q.cutoff    <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_GAIN:      prdata = PDATA_W'(cfg_q.gain);
			REG_SPAWN_THR: prdata = PDATA_W'(cfg_q.spawn_thr);
			REG_DECAY:     prdata = PDATA_W'(cfg_q.decay);
			REG_PITCH:     prdata = PDATA_W'(cfg_q.pitch);
			REG_CUTOFF:    prdata = PDATA_W'(cfg_q.cutoff);
			default:       prdata = '0;
		endcase
	end

	// sequencer
	assign accept    = s_tvalid && s_tready;
	assign last_slot = (vidx_q == VIDX_W'(MAX_VOICES - 1));
	assign out_load  = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (live_q[vidx_q]) state_nxt = ST_X2;
				else if (last_slot) state_nxt = ST_SPAWN;
			end
			ST_X2:     state_nxt = ST_MC;
			ST_MC:     state_nxt = ST_MB;
			ST_MB:     state_nxt = ST_MA;
			ST_MA:     state_nxt = ST_MM;
			ST_MM:     state_nxt = ST_MG;
			ST_MG:     state_nxt = ST_MP;
			ST_MP:     state_nxt = ST_MD;
			ST_MD:     state_nxt = ST_WR;
			ST_WR:     state_nxt = last_slot ? ST_SPAWN : ST_SCAN;
			ST_SPAWN:  state_nxt = ST_RETIRE;
			ST_RETIRE: state_nxt = ST_FIN;
			ST_FIN:    if (out_load) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mul_op   = OP_XX;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_X2:   mul_op   = OP_XX;
			ST_MC:   mul_op   = OP_C;
			ST_MB:   mul_op   = OP_B;
			ST_MA:   mul_op   = OP_A;
			ST_MM:   mul_op   = OP_MAG;
			ST_MG:   mul_op   = OP_GAIN;
			ST_MP:   mul_op   = OP_PITCH;
			ST_MD:   mul_op   = OP_DECAY;
			default: mul_op   = OP_XX;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vidx_q <= '0;
		end else if (accept) begin
			vidx_q <= '0;
		end else if (((state_q == ST_SCAN) && !live_q[vidx_q]) || (state_q == ST_WR)) begin
			if (!last_slot) vidx_q <= vidx_q + 1'b1;
		end
	end

	// quarter-wave argument from the phase
	assign sidx  = ph_q[PH_W-1 -: SINE_TABLE_BITS];
	assign quad  = sidx[SINE_TABLE_BITS-1 -: 2];
	assign frac  = sidx[SINE_TABLE_BITS-3:0];
	assign x_raw = X_W'(frac) << X_SHIFT;
	assign x_now = quad[0] ? (X_ONE - x_raw) : x_raw;

	// intermediate values taken from the last product
	assign x2_now  = prod[30:15];
	assign t1_now  = T1_W'(COEF_B - prod[30:15]);
	assign t2_now  = COEF_A - prod[30:15];
	assign p_now   = prod[31:15];
	assign mag_now = (p_now > AMP_W'(MAG_MAX)) ? MAG_MAX : p_now[MAG_W-1:0];
	assign term    = prod[47:28];

	always_comb begin
		mul_src.x       = (state_q == ST_X2) ? x_now : x_q;
		mul_src.x2      = (state_q == ST_MC) ? x2_now : x2_q;
		mul_src.t1      = t1_now;
		mul_src.t2      = t2_now;
		mul_src.mag     = mag_now;
		mul_src.amp     = amp_q;
		mul_src.amp_mag = prod[31:0];
		mul_src.gain    = cfg_q.gain;
		mul_src.pitch   = cfg_q.pitch;
		mul_src.decay   = cfg_q.decay;
	end

	gcs_mul_unit u_mul (
		.clk  (clk),
		.op   (mul_op),
		.src  (mul_src),
		.prod (prod)
	);

	// spawn slot search
	assign spawn_req = draw_q < cfg_q.spawn_thr;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = MAX_VOICES - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_any = 1'b1;
				free_idx = VIDX_W'(i);
			end
		end
	end

	assign spawn_go = (state_q == ST_SPAWN) && spawn_req && free_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (spawn_go) begin
			live_q[free_idx] <= 1'b1;
		end else if (state_q == ST_RETIRE) begin
			for (int i = 0; i < MAX_VOICES; i++) begin
				if (live_q[i] && (amp_mem_q[i] < cfg_q.cutoff)) live_q[i] <= 1'b0;
			end
		end
	end

	// voice store, only used where the live bit is set
	always_ff @(posedge clk) begin
		if (state_q == ST_WR) amp_mem_q[vidx_q] <= prod[32:16];
		if (state_q == ST_MD) phase_mem_q[vidx_q] <= ph_q + prod[31:16];
		if (spawn_go) begin
			amp_mem_q[free_idx]   <= AMP_ONE;
			phase_mem_q[free_idx] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			draw_q <= s_tdata;
			sum_q  <= '0;
		end
		if (state_q == ST_SCAN) begin
			amp_q <= amp_mem_q[vidx_q];
			ph_q  <= phase_mem_q[vidx_q];
		end
		if (state_q == ST_X2) begin
			x_q   <= x_now;
			neg_q <= quad[1];
		end
		if (state_q == ST_MC) x2_q <= x2_now;
		if (state_q == ST_MP) begin
			if (neg_q) sum_q <= sum_q - SUM_W'(term);
			else       sum_q <= sum_q + SUM_W'(term);
		end
		if (state_q == ST_SPAWN) begin
			if (sum_q > SUM_MAX) begin
				sample_q <= SUM_MAX[SAMPLE_W-1:0];
				clip_q   <= 1'b1;
			end else if (sum_q < SUM_MIN) begin
				sample_q <= SUM_MIN[SAMPLE_W-1:0];
				clip_q   <= 1'b1;
			end else begin
				sample_q <= sum_q[SAMPLE_W-1:0];
				clip_q   <= 1'b0;
			end
			dropped_q <= spawn_req && !free_any;
		end
	end

	// output register
	assign live_cnt = CNT_W'($countones(live_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {OUT_PAD_W'(0), ACT_W'(live_cnt), dropped_q, clip_q, sample_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again right after a transfer");

	a_voice_is_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_X2) |-> live_q[vidx_q])
		else $error("voice step started on a free slot");

	a_amp_no_growth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> (prod[32:16] <= amp_q))
		else $error("voice amplitude grew after decay");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_tvalid_q && (state_q == ST_IDLE)))
		else $error("result not presented after the sample finished");
`endif

endmodule

// ===== verif/tb_geiger_click_synthesizer_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the click synthesizer against a voice pool predictor
module tb_geiger_click_synthesizer_core;
	import gcs_pkg::*;

	typedef enum int {
		FLOW_FREE,
		FLOW_SEND_GAPS,
		FLOW_RECV_STALLS,
		FLOW_BOTH
	} flow_mode_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clipped;
		logic                       dropped;
		logic [ACT_W-1:0]           voices;
	} click_sample_t;

	localparam int HEAVY_PCT    = 72;
	localparam int LIGHT_PCT    = 14;
	localparam int PHASE_DRAWS  = 135;
	localparam int RANDOM_SETS  = 8;
	localparam int DRAIN_CYCLES = 200;
	localparam int PRINT_CAP    = 50;
	// first address past the register map, writes there must change nothing
	localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4 * (int'(REG_CUTOFF) + 1));

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [31:0] random_draw
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // [15:0] sample_out, [16] clipped, [17] spawn_dropped,
	                                         // [22:18] active_voices, [23] zero
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [PADDR_W-1:0]     paddr    = '0;
	logic [PDATA_W-1:0]     pwdata   = '0;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	geiger_click_synthesizer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #4 clk = ~clk;

	// predictor copy of the registers and the voice pool
	cfg_t            regs_mirror = CFG_RESET;
	bit [AMP_W-1:0]  voice_amp [MAX_VOICES];
	bit [PH_W-1:0]   voice_ph  [MAX_VOICES];
	bit              voice_on  [MAX_VOICES];

	logic [31:0]     pending_draws [$];
	click_sample_t   expected_samples [$];
	flow_mode_t      flow_mode = FLOW_FREE;

	int samples_seen;
	int mismatches;
	int clip_total;
	int drop_total;
	int peak_voices;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < PRINT_CAP)
			$display("[%0t] sample %0d: %s got %0d, expected %0d", $time, samples_seen, what, got,
				want);
		mismatches++;
	endtask

	function automatic bit roll_idle(input flow_mode_t side);
		case (flow_mode)
			FLOW_FREE: return 1'b0;
			FLOW_BOTH: return $urandom_range(99) < LIGHT_PCT;
			default:   return (flow_mode == side) && ($urandom_range(99) < HEAVY_PCT);
		endcase
	endfunction

	// quarter-wave polynomial sine, magnitude in Q15 and sign apart
	function automatic bit [MAG_W-1:0] sine_level(input bit [PH_W-1:0] ph, output bit neg);
		bit [SINE_TABLE_BITS-1:0] idx;
		bit [1:0]                 quad;
		bit [31:0]                x;
		bit [31:0]                x2;
		bit [31:0]                t;
		idx  = SINE_TABLE_BITS'(ph >> (16 - SINE_TABLE_BITS));
		quad = idx[SINE_TABLE_BITS-1 -: 2];
		x    = 32'(idx[SINE_TABLE_BITS-3:0]) << X_SHIFT;
		if (quad[0])
			x = 32'd32768 - x;
		neg = quad[1];
		x2 = (x * x) >> 15;
		t  = (32'(COEF_C) * x2) >> 15;
		t  = 32'(COEF_B) - t;
		t  = (t * x2) >> 15;
		t  = 32'(COEF_A) - t;
		t  = (x * t) >> 15;
		return (t > 32'd32767) ? MAG_MAX : t[MAG_W-1:0];
	endfunction

	// one audio sample: mix and update live voices, spawn, retire
	function automatic click_sample_t synth_sample(input bit [31:0] draw);
		click_sample_t     res;
		longint            sum;
		longint unsigned   term;
		bit [MAG_W-1:0]    mag;
		bit                neg;
		bit [AMP_W-1:0]    amp;
		bit                placed;
		int                live;
		sum = 0;
		live = 0;
		placed = 1'b0;
		res.clipped = 1'b0;
		res.dropped = 1'b0;
		for (int i = 0; i < MAX_VOICES; i++) begin
			if (voice_on[i]) begin
				amp  = voice_amp[i];
				mag  = sine_level(voice_ph[i], neg);
				term = (64'(amp) * 64'(mag) * 64'(regs_mirror.gain)) >> 28;
				sum += neg ? -longint'(term) : longint'(term);
				voice_ph[i]  = voice_ph[i] + 16'((32'(amp) * 32'(regs_mirror.pitch)) >> 16);
				voice_amp[i] = AMP_W'((64'(amp) * 64'(regs_mirror.decay)) >> 16);
			end
		end
		if (sum > 32767) begin
			sum = 32767;
			res.clipped = 1'b1;
		end else if (sum < -32768) begin
			sum = -32768;
			res.clipped = 1'b1;
		end
		res.sample = SAMPLE_W'(sum);
		if (draw < regs_mirror.spawn_thr) begin
			for (int i = 0; i < MAX_VOICES; i++) begin
				if (!placed && !voice_on[i]) begin
					voice_on[i]  = 1'b1;
					voice_amp[i] = AMP_ONE;
					voice_ph[i]  = '0;
					placed = 1'b1;
				end
			end
			res.dropped = !placed;
		end
		// a fresh voice is retired too when the cutoff is above full scale
		for (int i = 0; i < MAX_VOICES; i++) begin
			if (voice_on[i]) begin
				if (voice_amp[i] < regs_mirror.cutoff) begin
					voice_on[i]  = 1'b0;
					voice_amp[i] = '0;
					voice_ph[i]  = '0;
				end else begin
					live++;
				end
			end
		end
		res.voices = ACT_W'(live);
		return res;
	endfunction

	function automatic logic [PADDR_W-1:0] reg_addr(input cfg_reg_t r);
		return PADDR_W'({r, 2'b00});
	endfunction

	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr[1:0] == 2'b00) begin
			case (addr[PADDR_W-1:2])
				REG_GAIN:      regs_mirror.gain      = value[15:0];
				REG_SPAWN_THR: regs_mirror.spawn_thr = value;
				REG_DECAY:     regs_mirror.decay     = value[15:0];
				REG_PITCH:     regs_mirror.pitch     = value[15:0];
				REG_CUTOFF:    regs_mirror.cutoff    = value[16:0];
				default: ;
			endcase
		end
	endtask

	// junk in the unused upper bits must be dropped by the block
	task automatic apply_settings(input logic [15:0] g, input logic [31:0] thr,
			input logic [15:0] d, input logic [15:0] p, input logic [16:0] c);
		write_reg(reg_addr(REG_GAIN), {16'($urandom), g});
		write_reg(reg_addr(REG_SPAWN_THR), thr);
		write_reg(reg_addr(REG_DECAY), {16'($urandom), d});
		write_reg(reg_addr(REG_PITCH), {16'($urandom), p});
		write_reg(reg_addr(REG_CUTOFF), {15'($urandom), c});
	endtask

	task automatic wait_drained();
		while (pending_draws.size() != 0 || s_tvalid || expected_samples.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_draw(input int spawn_pct);
		int r;
		r = $urandom_range(99);
		if (r < spawn_pct && regs_mirror.spawn_thr != 0)
			return $urandom_range(regs_mirror.spawn_thr - 1, 0);
		else if (r >= 97)
			return r[0] ? 32'hffff_ffff : 32'd0;
		return $urandom;
	endfunction

	// draw sender
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				expected_samples.insert(expected_samples.size(), synth_sample(s_tdata));
			if (pending_draws.size() != 0 && !roll_idle(FLOW_SEND_GAPS)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= pending_draws.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sample receiver and checker
	always @(posedge clk) begin : sample_check
		click_sample_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_samples.size() == 0) begin
					report_mismatch("unexpected transfer, sample_out", $signed(m_tdata[15:0]), 0);
				end else begin
					want = expected_samples.pop_front();
					if (m_tdata[15:0] !== want.sample)
						report_mismatch("sample_out", $signed(m_tdata[15:0]), want.sample);
					if (m_tdata[16] !== want.clipped)
						report_mismatch("clipped", m_tdata[16], want.clipped);
					if (m_tdata[17] !== want.dropped)
						report_mismatch("spawn_dropped", m_tdata[17], want.dropped);
					if (m_tdata[22:18] !== want.voices)
						report_mismatch("active_voices", m_tdata[22:18], want.voices);
					clip_total += int'(want.clipped);
					drop_total += int'(want.dropped);
					if (int'(want.voices) > peak_voices)
						peak_voices = int'(want.voices);
				end
				samples_seen++;
			end
			m_tready <= !roll_idle(FLOW_RECV_STALLS);
		end
	end

	initial begin : stimulus
		int pct;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// fill the pool with slow-decaying voices at full gain: clipping, then dropped spawns
		apply_settings(16'hffff, 32'hffff_ffff, 16'hffff, 16'd8344, 17'd0);
		write_reg(SPARE_ADDR, $urandom);
		repeat (MAX_VOICES + 2) pending_draws.insert(pending_draws.size(), 32'd0);
		pending_draws.insert(pending_draws.size(), 32'hffff_ffff);
		wait_drained();

		// zero threshold never spawns, cutoff at the top retires everything
		write_reg(reg_addr(REG_SPAWN_THR), 32'd0);
		write_reg(reg_addr(REG_CUTOFF), 32'h1_ffff);
		pending_draws.insert(pending_draws.size(), 32'd0);
		pending_draws.insert(pending_draws.size(), 32'hffff_ffff);
		wait_drained();

		// a new voice dies in its own sample when the cutoff exceeds full scale
		write_reg(reg_addr(REG_SPAWN_THR), 32'hffff_ffff);
		pending_draws.insert(pending_draws.size(), 32'd0);
		pending_draws.insert(pending_draws.size(), 32'd1);
		wait_drained();

		for (int p = 0; p < RANDOM_SETS; p++) begin
			flow_mode = flow_mode_t'(p % 4);
			case (p)
				0: apply_settings(16'd4096, 32'h4000_0000, 16'd64881, 16'd8344, 17'd655);
				1: apply_settings(16'hffff, 32'h8000_0000, 16'hffff, 16'hffff, 17'd0);
				2: apply_settings(16'h0000, 32'hffff_ffff, 16'h0000, 16'h0000, 17'h1_0000);
				default: apply_settings(16'($urandom),
						($urandom_range(1)) ? $urandom : $urandom_range(32'h4000_0000, 0),
						($urandom_range(3) != 0) ? 16'($urandom_range(65535, 62000))
							: 16'($urandom_range(65535)),
						16'($urandom_range(65535)),
						($urandom_range(4) != 0) ? 17'($urandom_range(3000, 0))
							: 17'($urandom_range(131071, 0)));
			endcase
			if (p == RANDOM_SETS - 1)
				write_reg(SPARE_ADDR, $urandom);
			pct = $urandom_range(60, 10);
			for (int k = 0; k < PHASE_DRAWS; k++) begin
				// halfway the sender holds off until the block has delivered everything
				if (k == PHASE_DRAWS / 2)
					wait_drained();
				pending_draws.insert(pending_draws.size(), pick_draw(pct));
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_samples.size() != 0)
			report_mismatch("samples never delivered", 0, expected_samples.size());

		$display("checked %0d samples over %0d register settings and four flow-control patterns",
			samples_seen, RANDOM_SETS + 3);
		$display("%0d clipped, %0d spawns dropped on a full pool, up to %0d voices live",
			clip_total, drop_total, peak_voices);
		if (mismatches == 0)
			$display("geiger_click_synthesizer_core regression: pass");
		else
			$display("geiger_click_synthesizer_core regression: fail");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("geiger_click_synthesizer_core regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/gcs_pkg.sv
rtl/core/gcs_mul_unit.sv
rtl/core/geiger_click_synthesizer_core.sv
verif/tb_geiger_click_synthesizer_core.sv
